@@ src/djb_hash_bucket_index_macros.svh @@
// Assertion macros used by the hash block's controller.
// Every check is sampled on the rising clock and is off while reset is high.
`ifndef DJB_HASH_BUCKET_INDEX_MACROS_SVH
`define DJB_HASH_BUCKET_INDEX_MACROS_SVH

// Same-cycle implication.
`define DJB_ASSERT_IMPLY(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("djb hash assertion failed");

// Next-cycle implication.
`define DJB_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("djb hash assertion failed");

`endif

@@ src/djb_pkg.sv @@
package djb_pkg;

  localparam int HASH_W = 64;
  localparam int BKT_W  = 31;
  localparam int CNT_W  = 6;

  localparam logic [HASH_W-1:0] DJB_SEED  = 64'd5381;
  localparam int                DJB_SHIFT = 5;
  localparam logic [BKT_W-1:0]  BKT_RESET = 31'd1;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_LOAD,
    ST_DIVIDE,
    ST_DONE
  } djb_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic load;
    logic step;
    logic emit;
  } djb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic out_free;
  } djb_sts_t;

endpackage

@@ src/djb_if.sv @@
interface djb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_byte;

  modport source (output valid, data_byte, byte_valid, last_byte, input ready);
  modport sink (input valid, data_byte, byte_valid, last_byte, output ready);
endinterface

interface djb_out_if;
  logic               valid;
  logic               ready;
  logic [30:0]        bucket_index;
  logic signed [63:0] hash_value;

  modport source (output valid, bucket_index, hash_value, input ready);
  modport sink (input valid, bucket_index, hash_value, output ready);
endinterface

@@ src/djb_ctrl.sv @@
`include "djb_hash_bucket_index_macros.svh"

module djb_ctrl
  import djb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  input  djb_sts_t sts,
  output djb_cmd_t cmd
);

  djb_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_ACCUM: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && in_last) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.step = 1'b1;
        if (sts.div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // The remainder waits here until the output register can take it.
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

  `DJB_ASSERT_NEXT(a_last_starts_div, clk, rst, in_valid && in_ready && in_last, state == ST_LOAD)
  `DJB_ASSERT_NEXT(a_div_holds, clk, rst, state == ST_DIVIDE && !sts.div_done, state == ST_DIVIDE)
  `DJB_ASSERT_IMPLY(a_emit_free, clk, rst, cmd.emit, sts.out_free)
  `DJB_ASSERT_IMPLY(a_no_take_busy, clk, rst, cmd.load || cmd.step || cmd.emit, !cmd.take)

endmodule

@@ src/djb_dp.sv @@
module djb_dp
  import djb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  djb_cmd_t                 cmd,
  output djb_sts_t                 sts,
  input  logic [7:0]               data_byte,
  input  logic                     byte_valid,
  input  logic                     last_byte,
  input  logic                     cfg_we,
  input  logic [BKT_W-1:0]         cfg_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [BKT_W-1:0]         out_index,
  output logic [HASH_W-1:0]        out_hash
);

  logic [HASH_W-1:0] acc;
  logic [HASH_W-1:0] acc_next;
  logic [HASH_W-1:0] hash_reg;
  logic [HASH_W-1:0] magnitude;
  logic [HASH_W-1:0] dividend;
  logic [BKT_W-1:0]  rem;
  logic [BKT_W:0]    trial;
  logic [BKT_W:0]    diff;
  logic [BKT_W-1:0]  rem_next;
  logic [CNT_W-1:0]  cnt;
  logic [BKT_W-1:0]  bucket_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BKT_RESET;
    end else if (cfg_we) begin
      bucket_count <= cfg_data;
    end
  end

  // hash * 33 + sign-extended byte, wrapping at 64 bits.
  always_comb begin
    acc_next = acc;
    if (byte_valid) begin
      acc_next = (acc << DJB_SHIFT) + acc + {{(HASH_W-8){data_byte[7]}}, data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= DJB_SEED;
    end else if (cmd.take) begin
      acc <= last_byte ? DJB_SEED : acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && last_byte) begin
      hash_reg <= acc_next;
    end
  end

  // The most negative hash keeps its bit pattern, which reads as 2^63 unsigned.
  assign magnitude = hash_reg[HASH_W-1] ? (~hash_reg + 64'd1) : hash_reg;

  // Restoring division, one quotient bit per cycle; only the remainder is kept.
  assign trial    = {rem, dividend[HASH_W-1]};
  assign diff     = trial - {1'b0, bucket_count};
  assign rem_next = (trial >= {1'b0, bucket_count}) ? diff[BKT_W-1:0] : trial[BKT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dividend <= magnitude;
      rem      <= '0;
    end else if (cmd.step) begin
      dividend <= dividend << 1;
      rem      <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= '0;
    end else if (cmd.step) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_hash  <= hash_reg;
      out_index <= (bucket_count == '0) ? '0 : rem;
    end
  end

  assign sts.div_done = &cnt;
  assign sts.out_free = !out_valid || out_ready;

endmodule

@@ src/djb_hash_bucket_index.sv @@
// djb2 string hash with bucket index.
// Input channel "bytes": one request per string byte; data_byte is added as a
// signed char when byte_valid is high, and last_byte closes the string. An
// empty string is a single request with last_byte high and byte_valid low.
// Output channel "result": one request per string, carrying the 64-bit hash
// and the hash magnitude modulo bucket_count (zero when bucket_count is zero).
// The user must write bucket_count through cfg_we/cfg_data only while the
// block is idle; the block itself does not enforce this. Bytes inside a
// string are taken one per cycle. After the last byte the remainder is
// formed by a restoring divider, one bit per cycle over all 64 bits of the
// hash magnitude, and is then written to the output register; the next
// string is accepted only once the result has been written there.
// The result sits in an output register; while the receiver stalls it holds,
// and a finished remainder waits in the controller until that register frees.
// Synchronous reset sets the accumulator to 5381, bucket_count to 1 and
// empties the output register.
module djb_hash_bucket_index
  import djb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  djb_in_if.sink            bytes,
  djb_out_if.source         result,
  input  logic              cfg_we,
  input  logic [BKT_W-1:0]  cfg_data
);

  djb_cmd_t          cmd;
  djb_sts_t          sts;
  logic [HASH_W-1:0] out_hash;

  djb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (bytes.valid),
    .in_last  (bytes.last_byte),
    .in_ready (bytes.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  djb_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .data_byte  (bytes.data_byte),
    .byte_valid (bytes.byte_valid),
    .last_byte  (bytes.last_byte),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_index  (result.bucket_index),
    .out_hash   (out_hash)
  );

  assign result.hash_value = $signed(out_hash);

endmodule
